// File: hdl/dds_am_fm_wave_generator_defines.svh
// Assertion macros for the generator.
`ifndef DDS_AM_FM_WAVE_GENERATOR_DEFINES_SVH
`define DDS_AM_FM_WAVE_GENERATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, also during reset.
`define DDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/ddsamfm_pkg.sv
`timescale 1ns / 1ps
package ddsamfm_pkg;

    localparam int PHASE_W        = 32;
    localparam int VOL_W          = 16;
    localparam int IDX_W          = 10;
    localparam int SMP_BITS       = 12;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int WAVE_DEPTH_DEF = 1024;
    localparam int FM_DEPTH_DEF   = 512;

    localparam int SMP_MID    = 1 << (SMP_BITS - 1);
    localparam int SMP_FULL   = (1 << SMP_BITS) - 1;
    localparam int OUT_OFFSET = SMP_FULL * SMP_MID;
    localparam int DIV_W      = PHASE_W + SMP_BITS;

    localparam int MODE_EN = 0;
    localparam int MODE_AM = 1;
    localparam int MODE_FM = 2;

    localparam logic [VOL_W-1:0] VOLUME_RST = VOL_W'(42598);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WR_CAR = 2'd1,
        OP_WR_AM  = 2'd2,
        OP_WR_FM  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_CAR_STEP = 3'd1,
        CFG_AM_STEP  = 3'd2,
        CFG_FM_RATE  = 3'd3,
        CFG_FM_MIN   = 3'd4,
        CFG_FM_SPAN  = 3'd5,
        CFG_VOLUME   = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        K_TICK_OFF,
        K_TICK_ON,
        K_WR_CAR,
        K_WR_AM,
        K_WR_FM
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FM_MUL,
        S_FM_DIV,
        S_CAR,
        S_MUL1,
        S_MUL2,
        S_SCALE,
        S_OUT_DIV
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    idx;
        logic [SMP_BITS-1:0] val;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] carrier_step;
        logic [PHASE_W-1:0] am_step;
        logic [PHASE_W-1:0] fm_rate_step;
        logic [PHASE_W-1:0] fm_min_step;
        logic [PHASE_W-1:0] fm_span_step;
        logic [VOL_W-1:0]   volume;
    } t_cfg;

endpackage

// File: hdl/ddsamfm_front.sv
`timescale 1ns / 1ps
`include "dds_am_fm_wave_generator_defines.svh"
module ddsamfm_front import ddsamfm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_op,
    input  logic [IDX_W-1:0]    i_table_index,
    input  logic [SMP_BITS-1:0] i_table_value,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_cmd_pop
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       accept;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.idx = i_table_index;
        cmd_in.val = i_table_value;
        unique case (t_op'(i_op))
            OP_WR_CAR: cmd_in.kind = K_WR_CAR;
            OP_WR_AM:  cmd_in.kind = K_WR_AM;
            OP_WR_FM:  cmd_in.kind = K_WR_FM;
            default:   cmd_in.kind = i_cfg.mode[MODE_EN] ? K_TICK_ON : K_TICK_OFF;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!accept && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

    `DDS_ASSERT(a_pop_nonempty, i_cmd_pop |-> (r_cnt != 2'd0), "command pop from empty queue")

endmodule

// File: hdl/ddsamfm_div.sv
`timescale 1ns / 1ps
module ddsamfm_div import ddsamfm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend,
    output logic               o_busy,
    output logic               o_done,
    output logic [PHASE_W-1:0] o_quotient
);

    // x = hi*2^S + lo = hi*(2^S-1) + (hi+lo): fold until below 2^S
    logic               r_busy, r_done;
    logic [DIV_W-1:0]   r_rem;
    logic [PHASE_W-1:0] r_quo;
    logic [PHASE_W-1:0] hi;
    logic [SMP_BITS-1:0] lo;
    logic [DIV_W-1:0]   fold;

    assign hi   = r_rem[DIV_W-1:SMP_BITS];
    assign lo   = r_rem[SMP_BITS-1:0];
    assign fold = DIV_W'(hi) + DIV_W'(lo);

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && hi == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            if (hi != '0) begin
                r_rem <= fold;
                r_quo <= r_quo + hi;
            end else if (lo == SMP_BITS'(SMP_FULL)) begin
                r_quo <= r_quo + PHASE_W'(1);
            end
        end
    end

endmodule

// File: hdl/ddsamfm_core.sv
`timescale 1ns / 1ps
`include "dds_am_fm_wave_generator_defines.svh"
module ddsamfm_core import ddsamfm_pkg::*; #(
    parameter int WAVE_DEPTH = WAVE_DEPTH_DEF,
    parameter int FM_DEPTH   = FM_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output logic [SMP_BITS-1:0] o_res_data
);

    // depths are powers of two: slot is the top bits of the phase
    localparam int WAW  = $clog2(WAVE_DEPTH);
    localparam int FAW  = $clog2(FM_DEPTH);
    localparam int M1_W = VOL_W + SMP_BITS + 2;
    localparam int M2_W = M1_W + SMP_BITS + 1;
    localparam int T_W  = M2_W - VOL_W;
    localparam int U_W  = T_W + 1;

    logic [SMP_BITS-1:0] r_car_mem [WAVE_DEPTH];
    logic [SMP_BITS-1:0] r_am_mem  [WAVE_DEPTH];
    logic [SMP_BITS-1:0] r_fm_mem  [FM_DEPTH];
    logic [SMP_BITS-1:0] r_car_data, r_am_data, r_fm_data;

    t_state             r_state, n_state;
    logic [PHASE_W-1:0] r_fm_phase, n_fm_phase;
    logic [PHASE_W-1:0] r_car_phase, n_car_phase;
    logic [PHASE_W-1:0] r_am_phase, n_am_phase;
    logic [PHASE_W-1:0] r_inc, n_inc;
    logic signed [M1_W-1:0] r_m1, n_m1;
    logic signed [M2_W-1:0] r_m2, n_m2;

    logic                  fm_on, am_on;
    logic [PHASE_W-1:0]    fm_next;
    logic [IDX_W+WAW-1:0]  idx_w;
    logic [IDX_W+FAW-1:0]  idx_f;
    logic                  car_we, am_we, fm_we, car_rd, am_rd, fm_rd;
    logic signed [SMP_BITS:0] car_diff;
    logic [SMP_BITS-1:0]   am_val;
    logic signed [T_W-1:0] scaled;
    logic signed [U_W-1:0] shifted;
    logic [DIV_W-1:0]      fm_prod;
    logic                  div_start, div_busy, div_done;
    logic [DIV_W-1:0]      div_dividend;
    logic [PHASE_W-1:0]    div_q;

    assign fm_on   = i_cfg.mode[MODE_FM];
    assign am_on   = i_cfg.mode[MODE_AM];
    assign fm_next = fm_on ? r_fm_phase + i_cfg.fm_rate_step : r_fm_phase;
    assign idx_w   = (IDX_W+WAW)'(i_cmd.idx);
    assign idx_f   = (IDX_W+FAW)'(i_cmd.idx);

    assign car_diff = $signed({1'b0, r_car_data}) - $signed((SMP_BITS+1)'(SMP_MID));
    assign am_val   = am_on ? r_am_data : SMP_BITS'(SMP_FULL);
    assign n_m1     = $signed({1'b0, i_cfg.volume}) * car_diff;
    assign n_m2     = r_m1 * $signed({1'b0, am_val});
    assign scaled   = r_m2[M2_W-1:VOL_W];
    assign shifted  = U_W'(scaled) + $signed(U_W'(OUT_OFFSET));
    assign fm_prod  = DIV_W'(i_cfg.fm_span_step) * DIV_W'(r_fm_data);

    ddsamfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state      = r_state;
        n_fm_phase   = r_fm_phase;
        n_car_phase  = r_car_phase;
        n_am_phase   = r_am_phase;
        n_inc        = r_inc;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        car_we       = 1'b0;
        am_we        = 1'b0;
        fm_we        = 1'b0;
        car_rd       = 1'b0;
        am_rd        = 1'b0;
        fm_rd        = 1'b0;
        div_start    = 1'b0;
        div_dividend = fm_prod;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_WR_CAR: begin
                            car_we    = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        K_WR_AM: begin
                            am_we     = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        K_WR_FM: begin
                            fm_we     = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        K_TICK_OFF: begin
                            if (!i_res_full) begin
                                o_res_push = 1'b1;
                                o_cmd_pop  = 1'b1;
                            end
                        end
                        K_TICK_ON: begin
                            if (!i_res_full) begin
                                o_cmd_pop  = 1'b1;
                                fm_rd      = 1'b1;
                                n_fm_phase = fm_next;
                                n_state    = S_FM_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FM_MUL: begin
                if (fm_on) begin
                    div_start = 1'b1;
                    n_state   = S_FM_DIV;
                end else begin
                    n_inc   = i_cfg.carrier_step;
                    n_state = S_CAR;
                end
            end
            S_FM_DIV: begin
                if (div_done) begin
                    n_inc   = i_cfg.fm_min_step + div_q;
                    n_state = S_CAR;
                end
            end
            S_CAR: begin
                n_car_phase = r_car_phase + r_inc;
                n_am_phase  = am_on ? r_am_phase + i_cfg.am_step : r_am_phase;
                car_rd      = 1'b1;
                am_rd       = 1'b1;
                n_state     = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SCALE;
            S_SCALE: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(shifted[U_W-2:0]);
                n_state      = S_OUT_DIV;
            end
            S_OUT_DIV: begin
                if (div_done) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_data = (r_state == S_IDLE) ? SMP_BITS'(SMP_MID) : div_q[SMP_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fm_phase  <= '0;
            r_car_phase <= '0;
            r_am_phase  <= '0;
        end else begin
            r_state     <= n_state;
            r_fm_phase  <= n_fm_phase;
            r_car_phase <= n_car_phase;
            r_am_phase  <= n_am_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc <= n_inc;
        r_m1  <= n_m1;
        r_m2  <= n_m2;
    end

    always_ff @(posedge i_clk) begin
        if (car_we) begin
            r_car_mem[idx_w[WAW-1:0]] <= i_cmd.val;
        end
        if (car_rd) begin
            r_car_data <= r_car_mem[n_car_phase[PHASE_W-1 -: WAW]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (am_we) begin
            r_am_mem[idx_w[WAW-1:0]] <= i_cmd.val;
        end
        if (am_rd) begin
            r_am_data <= r_am_mem[n_am_phase[PHASE_W-1 -: WAW]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_fm_mem[idx_f[FAW-1:0]] <= i_cmd.val;
        end
        if (fm_rd) begin
            r_fm_data <= r_fm_mem[fm_next[PHASE_W-1 -: FAW]];
        end
    end

    `DDS_ASSERT(a_push_state, o_res_push |-> (r_state == S_IDLE || r_state == S_OUT_DIV), "result word pushed outside an output state")
    `DDS_ASSERT(a_push_room, o_res_push |-> !i_res_full, "result word pushed into a full queue")
    `DDS_ASSERT(a_div_idle, div_start |-> !div_busy, "divider started while busy")
    `DDS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE && !div_busy), "sequencer not idle after reset")

endmodule

// File: hdl/dds_am_fm_wave_generator.sv
`timescale 1ns / 1ps
// Write words: stored in the addressed table once the idle sequencer takes them.
// Tick words: with FM off, one output divide by 4095; with FM on, an FM divide by 4095
// first; both divides are fold-based. One tick at a time through the sequencer;
// disabled-channel ticks are pushed as mid scale straight from idle.
// Input and result queues hold 2 words each.
// Reset (synchronous, active low): phases and registers cleared, volume 42598; tables kept.
module dds_am_fm_wave_generator import ddsamfm_pkg::*; #(
    parameter int WAVE_DEPTH = WAVE_DEPTH_DEF,
    parameter int FM_DEPTH   = FM_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_op,
    input  logic [IDX_W-1:0]     i_table_index,
    input  logic [SMP_BITS-1:0]  i_table_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [SMP_BITS-1:0]  o_dac_code,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PHASE_W-1:0]   i_cfg_data
);

    t_cfg                r_cfg;
    logic                cmd_valid, cmd_pop;
    t_cmd                cmd;
    logic                res_push;
    logic [SMP_BITS-1:0] res_data;
    logic [SMP_BITS-1:0] r_res_mem [2];
    logic                r_res_wp, r_res_rp;
    logic [1:0]          r_res_cnt;
    logic                res_full, res_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= '0;
            r_cfg.carrier_step <= '0;
            r_cfg.am_step      <= '0;
            r_cfg.fm_rate_step <= '0;
            r_cfg.fm_min_step  <= '0;
            r_cfg.fm_span_step <= '0;
            r_cfg.volume       <= VOLUME_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MODE:     r_cfg.mode         <= i_cfg_data[MODE_W-1:0];
                CFG_CAR_STEP: r_cfg.carrier_step <= i_cfg_data;
                CFG_AM_STEP:  r_cfg.am_step      <= i_cfg_data;
                CFG_FM_RATE:  r_cfg.fm_rate_step <= i_cfg_data;
                CFG_FM_MIN:   r_cfg.fm_min_step  <= i_cfg_data;
                CFG_FM_SPAN:  r_cfg.fm_span_step <= i_cfg_data;
                CFG_VOLUME:   r_cfg.volume       <= i_cfg_data[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    ddsamfm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    ddsamfm_core #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .FM_DEPTH   (FM_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_data  (res_data)
    );

    // result queue
    assign res_full   = (r_res_cnt == 2'd2);
    assign empty      = (r_res_cnt == 2'd0);
    assign res_pop    = pop && !empty;
    assign o_dac_code = r_res_mem[r_res_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wp  <= 1'b0;
            r_res_rp  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (res_push) begin
                r_res_wp <= ~r_res_wp;
            end
            if (res_pop) begin
                r_res_rp <= ~r_res_rp;
            end
            if (res_push && !res_pop) begin
                r_res_cnt <= r_res_cnt + 2'd1;
            end else if (!res_push && res_pop) begin
                r_res_cnt <= r_res_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_mem[r_res_wp] <= res_data;
        end
    end

endmodule

// File: verif/tb_dds_am_fm_wave_generator.sv
`timescale 1ns / 1ps
module tb_dds_am_fm_wave_generator;
    import ddsamfm_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int MAX_GAP         = 14;
    localparam int HOLD_CYCLES     = 400;
    localparam int BURST_WORDS     = 40;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 170;
    localparam int MAX_REPORTS     = 200;
    localparam int WAVE_BITS       = $clog2(WAVE_DEPTH_DEF);
    localparam int FM_BITS         = $clog2(FM_DEPTH_DEF);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [1:0]           i_op;
    logic [IDX_W-1:0]     i_table_index;
    logic [SMP_BITS-1:0]  i_table_value;
    logic                 empty;
    logic                 pop;
    logic [SMP_BITS-1:0]  o_dac_code;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PHASE_W-1:0]   i_cfg_data;

    dds_am_fm_wave_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .empty         (empty),
        .pop           (pop),
        .o_dac_code    (o_dac_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // generator shadow: registers, phases, wave tables
    logic [MODE_W-1:0]   gen_mode;
    logic [PHASE_W-1:0]  gen_car_step;
    logic [PHASE_W-1:0]  gen_am_step;
    logic [PHASE_W-1:0]  gen_fm_rate;
    logic [PHASE_W-1:0]  gen_fm_min;
    logic [PHASE_W-1:0]  gen_fm_span;
    logic [VOL_W-1:0]    gen_volume;
    logic [PHASE_W-1:0]  car_phase;
    logic [PHASE_W-1:0]  am_phase;
    logic [PHASE_W-1:0]  fm_phase;
    logic [SMP_BITS-1:0] car_wave [WAVE_DEPTH_DEF];
    logic [SMP_BITS-1:0] am_wave  [WAVE_DEPTH_DEF];
    logic [SMP_BITS-1:0] fm_wave  [FM_DEPTH_DEF];

    logic [SMP_BITS-1:0] dac_expected[$];
    int                  err_count = 0;
    bit                  tx_no_gap = 1'b0;
    bit                  rx_no_stall = 1'b0;
    int                  rx_hold_len = 0;

    function automatic void reset_generator();
        gen_mode     = '0;
        gen_car_step = '0;
        gen_am_step  = '0;
        gen_fm_rate  = '0;
        gen_fm_min   = '0;
        gen_fm_span  = '0;
        gen_volume   = VOLUME_RST;
        car_phase    = '0;
        am_phase     = '0;
        fm_phase     = '0;
    endfunction

    function automatic void load_wave(t_op op, logic [IDX_W-1:0] idx,
                                      logic [SMP_BITS-1:0] val);
        case (op)
            OP_WR_CAR: car_wave[idx % WAVE_DEPTH_DEF] = val;
            OP_WR_AM:  am_wave[idx % WAVE_DEPTH_DEF] = val;
            OP_WR_FM:  fm_wave[idx % FM_DEPTH_DEF] = val;
            default: ;
        endcase
    endfunction

    // advance phases for one tick (none when the channel is disabled) and return the DAC code it yields
    function automatic logic [SMP_BITS-1:0] synth_tick();
        logic [PHASE_W-1:0]  inc;
        logic [SMP_BITS-1:0] car_s;
        logic [SMP_BITS-1:0] am_s;
        logic [SMP_BITS-1:0] fm_s;
        longint              num;
        longint              den;
        longint              q;
        if (!gen_mode[MODE_EN]) begin
            return SMP_BITS'(SMP_MID);
        end
        if (gen_mode[MODE_FM]) begin
            fm_phase = fm_phase + gen_fm_rate;
            fm_s = fm_wave[fm_phase[PHASE_W-1 -: FM_BITS]];
            inc = gen_fm_min
                + PHASE_W'((64'(gen_fm_span) * 64'(fm_s)) / 64'(SMP_FULL));
        end else begin
            inc = gen_car_step;
        end
        car_phase = car_phase + inc;
        car_s = car_wave[car_phase[PHASE_W-1 -: WAVE_BITS]];
        if (gen_mode[MODE_AM]) begin
            am_phase = am_phase + gen_am_step;
            am_s = am_wave[am_phase[PHASE_W-1 -: WAVE_BITS]];
        end else begin
            am_s = SMP_BITS'(SMP_FULL);
        end
        num = longint'(gen_volume) * (longint'(car_s) - SMP_MID) * longint'(am_s);
        den = longint'(65536) * SMP_FULL;
        q = num / den;
        if (num < 0 && (num % den) != 0) begin
            q = q - 1;
        end
        return SMP_BITS'(SMP_MID + q);
    endfunction

    function automatic logic [PHASE_W-1:0] draw_step();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2, 3: return PHASE_W'($urandom_range(1, 1 << 24));
            default: return PHASE_W'($urandom);
        endcase
    endfunction

    task automatic push_word(t_op op, logic [IDX_W-1:0] idx, logic [SMP_BITS-1:0] val);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_op          <= op;
        i_table_index <= idx;
        i_table_value <= val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (op == OP_TICK) begin
            dac_expected.push_back(synth_tick());
        end else begin
            load_wave(op, idx, val);
        end
    endtask

    // wait out every pending word, including writes still in flight
    task automatic settle_block();
        push <= 1'b0;
        while (dac_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PHASE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:     gen_mode = data[MODE_W-1:0];
            CFG_CAR_STEP: gen_car_step = data;
            CFG_AM_STEP:  gen_am_step = data;
            CFG_FM_RATE:  gen_fm_rate = data;
            CFG_FM_MIN:   gen_fm_min = data;
            CFG_FM_SPAN:  gen_fm_span = data;
            CFG_VOLUME:   gen_volume = data[VOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(logic [MODE_W-1:0] mode, logic [PHASE_W-1:0] car_step,
                               logic [PHASE_W-1:0] am_step, logic [PHASE_W-1:0] fm_rate,
                               logic [PHASE_W-1:0] fm_min, logic [PHASE_W-1:0] fm_span,
                               logic [VOL_W-1:0] volume);
        settle_block();
        write_reg(CFG_MODE, PHASE_W'(mode));
        write_reg(CFG_CAR_STEP, car_step);
        write_reg(CFG_AM_STEP, am_step);
        write_reg(CFG_FM_RATE, fm_rate);
        write_reg(CFG_FM_MIN, fm_min);
        write_reg(CFG_FM_SPAN, fm_span);
        write_reg(CFG_VOLUME, PHASE_W'(volume));
    endtask

    // disabled channel: tables untouched so far, output must sit at mid scale
    task automatic test_disabled_channel();
        push_word(OP_TICK, '0, '0);
        push_word(OP_TICK, '1, '1);
        apply_setup(3'b110, 32'h0123_4567, 32'h89AB_CDEF, 32'h0F0F_0F0F,
                    32'h1000_0000, 32'h2000_0000, 16'd30000);
        repeat (3) push_word(OP_TICK, IDX_W'($urandom), SMP_BITS'($urandom));
    endtask

    task automatic test_table_load();
        for (int i = 0; i < WAVE_DEPTH_DEF; i++) begin
            push_word(OP_WR_CAR, IDX_W'(i), SMP_BITS'($urandom));
        end
        for (int i = 0; i < WAVE_DEPTH_DEF; i++) begin
            push_word(OP_WR_AM, IDX_W'(i), SMP_BITS'($urandom));
        end
        // upper index bit is don't-care for the FM table
        for (int i = 0; i < FM_DEPTH_DEF; i++) begin
            push_word(OP_WR_FM, {1'($urandom), 9'(i)}, SMP_BITS'($urandom));
        end
    endtask

    task automatic test_directed_extremes();
        apply_setup(3'b001, '0, '0, '0, '0, '0, '1);
        push_word(OP_WR_CAR, '0, '1);
        push_word(OP_TICK, '0, '0);
        push_word(OP_WR_CAR, '0, '0);
        push_word(OP_TICK, '0, '0);
        push_word(OP_WR_CAR, '0, SMP_BITS'(SMP_MID));
        push_word(OP_TICK, '0, '0);
        // unmapped register index must leave everything alone
        settle_block();
        write_reg(CFG_UNUSED, '1);
        push_word(OP_WR_CAR, '0, '1);
        push_word(OP_TICK, '0, '0);
        apply_setup(3'b011, '0, '0, '0, '0, '0, '1);
        push_word(OP_WR_AM, '0, '0);
        push_word(OP_TICK, '0, '0);
        push_word(OP_WR_AM, '0, '1);
        push_word(OP_WR_AM, '1, '1);
        push_word(OP_WR_CAR, '1, '1);
        push_word(OP_TICK, '0, '0);
        // FM increment sums wrap at 32 bits
        apply_setup(3'b111, '0, '0, '0, '1, '1, '1);
        push_word(OP_WR_FM, '1, '1);
        push_word(OP_WR_FM, '0, '1);
        push_word(OP_TICK, '0, '0);
        push_word(OP_TICK, '0, '0);
        push_word(OP_WR_FM, IDX_W'(FM_DEPTH_DEF), '0);
        push_word(OP_TICK, '0, '0);
        apply_setup(3'b001, '0, '0, '0, '0, '0, '0);
        push_word(OP_TICK, '0, '0);
    endtask

    task automatic test_backpressure();
        apply_setup(3'b111, draw_step(), draw_step(), draw_step(), draw_step(),
                    draw_step(), VOL_W'($urandom));
        rx_hold_len = HOLD_CYCLES;
        tx_no_gap = 1'b1;
        repeat (BURST_WORDS) push_word(OP_TICK, IDX_W'($urandom), SMP_BITS'($urandom));
        tx_no_gap = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            logic [MODE_W-1:0] mode;
            logic [VOL_W-1:0]  volume;
            bit                stretch;
            mode = (ph < 8) ? MODE_W'(ph) : MODE_W'($urandom);
            case ($urandom_range(0, 3))
                0: volume = '0;
                1: volume = '1;
                default: volume = VOL_W'($urandom);
            endcase
            if (ph == 8) begin
                apply_setup('1, '1, '1, '1, '1, '1, '1);
            end else begin
                apply_setup(mode, draw_step(), draw_step(), draw_step(), draw_step(),
                            draw_step(), volume);
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 60 == 0) begin
                    stretch = ($urandom_range(0, 3) == 0);
                    tx_no_gap = stretch;
                    rx_no_stall = stretch;
                end
                case ($urandom_range(0, 9))
                    7: push_word(OP_WR_CAR, IDX_W'($urandom), SMP_BITS'($urandom));
                    8: push_word(OP_WR_AM, IDX_W'($urandom), SMP_BITS'($urandom));
                    9: push_word(OP_WR_FM, IDX_W'($urandom), SMP_BITS'($urandom));
                    default: push_word(OP_TICK, IDX_W'($urandom), SMP_BITS'($urandom));
                endcase
            end
            tx_no_gap = 1'b0;
            rx_no_stall = 1'b0;
        end
    endtask

    initial begin : result_sink
        int                  pause;
        logic [SMP_BITS-1:0] want;
        pop <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                pause = rx_hold_len;
            end else if (rx_no_stall) begin
                pause = 0;
            end else begin
                pause = $urandom_range(0, MAX_GAP);
            end
            rx_hold_len = 0;
            if (pause > 0) begin
                pop <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (dac_expected.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected dac_code word, expected none, got %0d",
                             $time, o_dac_code);
                end
            end else begin
                want = dac_expected.pop_front();
                if (o_dac_code !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: dac_code mismatch, expected %0d, got %0d",
                                 $time, want, o_dac_code);
                    end
                end
            end
        end
    end

    initial begin
        push          <= 1'b0;
        i_op          <= OP_TICK;
        i_table_index <= '0;
        i_table_value <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_MODE;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        reset_generator();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_channel();
        test_table_load();
        test_directed_extremes();
        test_backpressure();
        test_random_traffic();
        settle_block();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
